/* rtl/pcrp_pkg.sv */
// Package for the per-clock rate projection block: constants, command codes,
// controller/datapath command and status structs. No dependencies.
package pcrp_pkg;

  localparam int NumClocks = 3;
  localparam int IdW = 4;
  localparam int IdxW = (NumClocks > 1) ? $clog2(NumClocks) : 1;
  localparam logic [63:0] NsPerS = 64'd1000000000;
  localparam logic [31:0] NominalReset = 32'd600000000;
  localparam int DivSteps = 64;

  typedef enum logic [2:0] {
    CMD_UPDATE   = 3'd0,
    CMD_EPOCH    = 3'd1,
    CMD_PROJECT  = 3'd2,
    CMD_SNAPSHOT = 3'd3,
    CMD_RESET    = 3'd4
  } cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the input beat, read the entry
    logic mul_start;  // form numerator and divisor
    logic div_start;  // start the divider
    logic commit;     // write back entry and form the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;   // this item needs a division
    logic div_done;
  } dp_sts_t;

endpackage

/* rtl/pcrp_div.sv */
// Restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on pcrp_pkg.
module pcrp_div
  import pcrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign shifted = {rem_r, quo_r[63]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = 7'(DivSteps);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = busy_r && (cnt_r == 7'd1);
  assign quotient = quo_nxt;

endmodule

/* rtl/pcrp_datapath.sv */
// Datapath: entry registers, numerator multiply, divider and result forming.
// Depends on pcrp_pkg and pcrp_div.
module pcrp_datapath
  import pcrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_sts_t      sts,
  input  logic [31:0]  nominal,
  input  logic [2:0]   in_cmd,
  input  logic [IdW-1:0] in_id,
  input  logic [31:0]  in_cs,
  input  logic [63:0]  in_ns,
  output logic [354:0] res
);

  logic [NumClocks-1:0] vld_r, rvld_r;
  logic [31:0] anc_c_r  [NumClocks];
  logic [63:0] anc_n_r  [NumClocks];
  logic [31:0] rate_r   [NumClocks];
  logic [31:0] cnt_r    [NumClocks];
  logic [31:0] obs_c_r  [NumClocks];
  logic [63:0] obs_n_r  [NumClocks];
  logic [31:0] chg_r    [NumClocks];

  // latched item and entry copy
  logic [2:0]  c_r;
  logic        known_r;
  logic [IdxW-1:0] k_r;
  logic [31:0] cs_r;
  logic [63:0] ns_r;
  logic        e_vld_r, e_rvld_r;
  logic [31:0] e_anc_c_r, e_rate_r;
  logic [63:0] e_anc_n_r;
  logic [31:0] dc_r;
  logic [63:0] dn_r;
  logic [63:0] num_r, den_r;

  logic        known;
  logic [IdxW-1:0] k;
  logic [31:0] dc;
  logic [63:0] dn;
  logic        div_done;
  logic [63:0] quo;
  logic        need_div;

  assign known = (in_id < IdW'(NumClocks));
  assign k     = known ? in_id[IdxW-1:0] : '0;
  assign dc    = cs_r - e_anc_c_r;
  assign dn    = (ns_r >= e_anc_n_r) ? ns_r - e_anc_n_r : 64'd0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r       <= in_cmd;
      known_r   <= known;
      k_r       <= k;
      cs_r      <= in_cs;
      ns_r      <= in_ns;
      e_vld_r   <= vld_r[k];
      e_rvld_r  <= rvld_r[k];
      e_anc_c_r <= anc_c_r[k];
      e_anc_n_r <= anc_n_r[k];
      e_rate_r  <= rate_r[k];
    end
    if (cmd.mul_start) begin
      dc_r <= dc;
      dn_r <= dn;
      if (c_r == CMD_PROJECT) begin
        num_r <= 64'(dc) * NsPerS + {33'd0, e_rate_r[31:1]};
        den_r <= {32'd0, e_rate_r};
      end else begin
        num_r <= 64'(dc) * NsPerS + {1'b0, dn[63:1]};
        den_r <= dn;
      end
    end
  end

  pcrp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(num_r), .divisor(den_r), .done(div_done), .quotient(quo)
  );

  assign need_div = known_r &&
    (((c_r == CMD_UPDATE) && e_vld_r && (dc != 32'd0) && (dn != 64'd0)) ||
     ((c_r == CMD_PROJECT) && e_vld_r && e_rvld_r && (e_rate_r != 32'd0)));
  assign sts = '{need_div: need_div, div_done: div_done};

  logic [63:0] q_r;
  always_ff @(posedge clk) if (div_done) q_r <= quo;

  logic [31:0] q32;
  logic signed [33:0] d34;
  logic [31:0] chg_sat;
  assign q32 = (q_r[63:32] != 32'd0) ? 32'hFFFFFFFF : q_r[31:0];
  assign d34 = $signed({2'b00, q32}) - $signed({2'b00, e_rate_r});
  always_comb begin
    if (d34 > 34'sh7FFFFFFF) chg_sat = 32'h7FFFFFFF;
    else if (d34 < -34'sh80000000) chg_sat = 32'h80000000;
    else chg_sat = d34[31:0];
  end

  logic        ok;
  logic [63:0] pns;
  logic [31:0] s_rate, s_chg, s_cnt, s_obc, s_anc;
  logic [63:0] s_obn, s_ann;
  logic        s_v, s_rv;

  always_comb begin
    ok = 1'b0; pns = '0; s_v = 1'b0; s_rv = 1'b0; s_rate = '0; s_chg = '0;
    s_cnt = '0; s_obc = '0; s_obn = '0; s_anc = '0; s_ann = '0;
    case (c_r)
      CMD_UPDATE, CMD_EPOCH: ok = known_r;
      CMD_PROJECT: begin
        if (need_div) begin
          ok  = 1'b1;
          pns = e_anc_n_r + q_r;
        end
      end
      CMD_SNAPSHOT: begin
        if (known_r) begin
          ok = 1'b1; s_v = vld_r[k_r]; s_rv = rvld_r[k_r]; s_rate = rate_r[k_r];
          s_chg = chg_r[k_r]; s_cnt = cnt_r[k_r]; s_obc = obs_c_r[k_r];
          s_obn = obs_n_r[k_r]; s_anc = anc_c_r[k_r]; s_ann = anc_n_r[k_r];
        end
      end
      CMD_RESET: ok = 1'b1;
      default: ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) res <= {s_ann, s_anc, s_obn, s_obc, s_cnt, s_chg, s_rate,
                            s_rv, s_v, pns, ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= '0;
      for (int i = 0; i < NumClocks; i++) begin
        anc_c_r[i] <= '0; anc_n_r[i] <= '0; rate_r[i] <= NominalReset;
        cnt_r[i] <= '0; obs_c_r[i] <= '0; obs_n_r[i] <= '0; chg_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (c_r == CMD_RESET) begin
        vld_r  <= '0;
        rvld_r <= '0;
        for (int i = 0; i < NumClocks; i++) begin
          anc_c_r[i] <= '0; anc_n_r[i] <= '0; rate_r[i] <= nominal;
          cnt_r[i] <= '0; obs_c_r[i] <= '0; obs_n_r[i] <= '0; chg_r[i] <= '0;
        end
      end else if (known_r && c_r == CMD_EPOCH) begin
        vld_r[k_r] <= 1'b1; rvld_r[k_r] <= 1'b1;
        anc_c_r[k_r] <= cs_r; anc_n_r[k_r] <= ns_r; rate_r[k_r] <= nominal;
        cnt_r[k_r] <= '0; obs_c_r[k_r] <= '0; obs_n_r[k_r] <= '0; chg_r[k_r] <= '0;
      end else if (known_r && c_r == CMD_UPDATE) begin
        if (!e_vld_r) begin
          rate_r[k_r] <= nominal; rvld_r[k_r] <= 1'b1; chg_r[k_r] <= '0;
          obs_c_r[k_r] <= '0; obs_n_r[k_r] <= '0;
        end else if (need_div) begin
          chg_r[k_r]   <= e_rvld_r ? chg_sat : 32'd0;
          rate_r[k_r]  <= (q32 != 32'd0) ? q32 : nominal;
          rvld_r[k_r]  <= 1'b1;
          obs_c_r[k_r] <= dc_r;
          obs_n_r[k_r] <= dn_r;
        end
        vld_r[k_r]   <= 1'b1;
        anc_c_r[k_r] <= cs_r;
        anc_n_r[k_r] <= ns_r;
        cnt_r[k_r]   <= cnt_r[k_r] + 32'd1;
      end
    end
  end

endmodule

/* rtl/pcrp_ctrl.sv */
// Controller state machine: input/output handshakes and datapath sequencing.
// Depends on pcrp_pkg.
module pcrp_ctrl
  import pcrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_WAIT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovld_r, ovld_nxt;

  assign in_tready  = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    ovld_nxt  = ovld_r;
    cmd       = '0;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        cmd.load  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else state_nxt = S_DONE;
      end
      S_DIV: if (sts.div_done) state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_DONE;
      S_DONE: begin
        cmd.commit = 1'b1;
        ovld_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

/* rtl/per_clock_rate_projection_top.sv */
// Per-clock rate projection, one item at a time. A project command on a known,
// anchored entry with a valid nonzero rate, or an update on a known, anchored
// entry with nonzero cycle and ns differences, goes through entry read,
// numerator multiply, the restoring divider, quotient capture and write-back.
// Every other command skips the divider. One result beat per input beat; the
// next input is taken once the previous result has been taken. cfg writes set
// the nominal rate used on first update, epoch reset, reset-all and when a
// measured rate rounds to zero.
// Depends on pcrp_pkg, pcrp_ctrl, pcrp_datapath, pcrp_div.
module per_clock_rate_projection_top
  import pcrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] command, [6:3] clock_id, [38:7] cycle_stamp, [102:39] ns_stamp
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] ok, [64:1] projected_ns, [65] entry_valid, [66] rate_valid,
  // [98:67] rate, [130:99] rate_change, [162:131] upd_count,
  // [194:163] last_obs_cycles, [258:195] last_obs_ns,
  // [290:259] anchor_cycles, [354:291] anchor_ns
  output logic [359:0] out_tdata
);

  logic [31:0] nominal_r;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [354:0] res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) nominal_r <= NominalReset;
    else if (cfg_valid) nominal_r <= cfg_data;
  end

  pcrp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .sts(sts)
  );

  pcrp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .nominal(nominal_r),
    .in_cmd(in_tdata[2:0]), .in_id(in_tdata[6:3]), .in_cs(in_tdata[38:7]),
    .in_ns(in_tdata[102:39]), .res(res)
  );

  assign out_tdata = {5'd0, res};

endmodule
